FILE: design/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types, default sizes and helper functions for the set-associative
// cache tag lookup.
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int SAC_CACHE_BYTES  = 262144;
  localparam int SAC_BLOCK_BYTES  = 64;
  localparam int SAC_WAYS         = 8;
  localparam int SAC_ADDRESS_BITS = 32;

  // width of the address port and of the way_used field
  localparam int SAC_ADDR_PORT_W = 32;
  localparam int SAC_WAY_OUT_W   = 3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } sac_state_t;

  function automatic int floor_log2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n = n + 1;
    end
    return n;
  endfunction

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: design/set_assoc_cache_lru_lookup.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup
// Tag store of a set-associative cache with true LRU replacement.
// ----------------------------------------------------------------------------
// Each accepted address is taken in ST_IDLE, which reads the set row from
// the synchronous tag and metadata RAMs; ST_LOOK then compares, picks the
// hit or victim way and writes the row back, after which the result item
// is loaded into the output register. A new address is taken only once the
// block is back in ST_IDLE and the output register is free or being
// drained, so no address is accepted while one is in flight; the
// read-modify-write of the set row in the single-ported-per-direction RAMs
// sets that limit. After reset the block clears the valid bits and recency
// order of every set, one set per cycle, and holds in_tready low meanwhile.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup import sac_pkg::*; #(
  parameter int CACHE_BYTES  = SAC_CACHE_BYTES,
  parameter int BLOCK_BYTES  = SAC_BLOCK_BYTES,
  parameter int WAYS         = SAC_WAYS,
  parameter int ADDRESS_BITS = SAC_ADDRESS_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] address
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] hit, [3:1] way_used, [7:4] zero
);

  localparam int SETS_RAW = CACHE_BYTES / (BLOCK_BYTES * WAYS);
  localparam int SETS     = (SETS_RAW > 0) ? SETS_RAW : 1;
  localparam int OB       = floor_log2(BLOCK_BYTES);
  localparam int IB       = floor_log2(SETS);
  localparam int AW_EFF   = (ADDRESS_BITS < SAC_ADDR_PORT_W) ? ADDRESS_BITS : SAC_ADDR_PORT_W;
  localparam int TAG_W    = max_int(1, AW_EFF - OB - IB);
  localparam int SET_W    = max_int(1, IB);
  localparam int WAY_W    = max_int(1, $clog2(WAYS));
  localparam int META_W   = WAYS + WAYS * WAY_W;
  localparam logic [SAC_ADDR_PORT_W-1:0] ADDR_MASK =
    (AW_EFF >= SAC_ADDR_PORT_W) ? '1 : SAC_ADDR_PORT_W'((64'd1 << AW_EFF) - 64'd1);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'((2 ** SET_W) - 1);

  sac_state_t state_r, state_nxt;

  logic [SET_W-1:0]          clr_cnt_r;
  logic [SET_W-1:0]          set_r;
  logic [TAG_W-1:0]          tag_r;
  logic                      out_tvalid_r;
  logic                      hit_r;
  logic [SAC_WAY_OUT_W-1:0]  way_r;

  logic [SAC_ADDR_PORT_W-1:0] addr_m;
  logic [SAC_ADDR_PORT_W-1:0] set_shift;
  logic [SAC_ADDR_PORT_W-1:0] tag_shift;
  logic [SET_W-1:0]           in_set;
  logic [TAG_W-1:0]           in_tag;
  logic                       in_acc;

  logic [WAYS*TAG_W-1:0] tag_rdata;
  logic [META_W-1:0]     meta_rdata;
  logic                  tag_we;
  logic                  meta_we;
  logic [SET_W-1:0]      meta_waddr;
  logic [META_W-1:0]     meta_wdata;
  logic [META_W-1:0]     meta_rst;

  logic                  lk_hit;
  logic [WAY_W-1:0]      lk_way;
  logic [WAYS*TAG_W-1:0] lk_tag_row;
  logic [WAYS-1:0]       lk_valid;
  logic [WAYS*WAY_W-1:0] lk_order;
  logic [WAY_W+SAC_WAY_OUT_W-1:0] way_ext;

  // split the address into set index and tag
  always_comb begin
    addr_m    = in_tdata & ADDR_MASK;
    set_shift = addr_m >> OB;
    tag_shift = addr_m >> (OB + IB);
    in_set    = (IB == 0) ? '0 : set_shift[SET_W-1:0];
    in_tag    = tag_shift[TAG_W-1:0];
  end

  assign in_tready = (state_r == ST_IDLE) && (!out_tvalid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    meta_rst = '0;
    for (int i = 0; i < WAYS; i++) begin
      meta_rst[WAYS + i*WAY_W +: WAY_W] = WAY_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + SET_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    tag_we     = 1'b0;
    meta_we    = 1'b0;
    meta_waddr = set_r;
    meta_wdata = {lk_order, lk_valid};
    case (state_r)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_cnt_r;
        meta_wdata = meta_rst;
        if (clr_cnt_r == LAST_SET) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        meta_we   = 1'b1;
        tag_we    = !lk_hit;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // hold the split address while the set row is read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      set_r <= in_set;
      tag_r <= in_tag;
    end
  end

  sac_ram #(
    .WIDTH  (WAYS * TAG_W),
    .ADDR_W (SET_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (set_r),
    .wdata (lk_tag_row),
    .re    (in_acc),
    .raddr (in_set),
    .rdata (tag_rdata)
  );

  sac_ram #(
    .WIDTH  (META_W),
    .ADDR_W (SET_W)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (in_acc),
    .raddr (in_set),
    .rdata (meta_rdata)
  );

  sac_lru_unit #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W),
    .WAY_W (WAY_W)
  ) u_lru_unit (
    .tag         (tag_r),
    .tag_row     (tag_rdata),
    .valid       (meta_rdata[WAYS-1:0]),
    .order       (meta_rdata[META_W-1:WAYS]),
    .hit         (lk_hit),
    .way         (lk_way),
    .tag_row_nxt (lk_tag_row),
    .valid_nxt   (lk_valid),
    .order_nxt   (lk_order)
  );

  assign way_ext = {{SAC_WAY_OUT_W{1'b0}}, lk_way};

  // output register: the lookup state only runs when it is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_LOOK) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOOK) begin
      hit_r <= lk_hit;
      way_r <= way_ext[SAC_WAY_OUT_W-1:0];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, way_r, hit_r};

endmodule

FILE: design/sac_ram.sv
// ----------------------------------------------------------------------------
// sac_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module sac_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/sac_lru_unit.sv
// ----------------------------------------------------------------------------
// sac_lru_unit
// Compares the tag against every valid way of one set, picks the hit way or
// the least recently used victim, and builds the updated set row: tags,
// valid bits and recency order (entry 0 oldest).
// ----------------------------------------------------------------------------
module sac_lru_unit #(
  parameter int WAYS  = 8,
  parameter int TAG_W = 17,
  parameter int WAY_W = 3
) (
  input  logic [TAG_W-1:0]      tag,
  input  logic [WAYS*TAG_W-1:0] tag_row,
  input  logic [WAYS-1:0]       valid,
  input  logic [WAYS*WAY_W-1:0] order,
  output logic                  hit,
  output logic [WAY_W-1:0]      way,
  output logic [WAYS*TAG_W-1:0] tag_row_nxt,
  output logic [WAYS-1:0]       valid_nxt,
  output logic [WAYS*WAY_W-1:0] order_nxt
);

  logic [WAYS-1:0]  match;
  logic [WAYS-1:0]  pos_match;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] victim;
  logic             shift_acc;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = valid[w] && (tag_row[w*TAG_W +: TAG_W] == tag);
    end
    hit = |match;

    // lowest matching way wins
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
    end

    victim = order[0 +: WAY_W];
    if (int'(victim) >= WAYS) begin
      victim = '0;
    end

    way = hit ? hit_way : victim;

    // drop the way from its place in the order, close the gap, append it
    for (int i = 0; i < WAYS; i++) begin
      pos_match[i] = (order[i*WAY_W +: WAY_W] == way);
    end
    shift_acc = 1'b0;
    order_nxt = order;
    for (int i = 0; i < WAYS - 1; i++) begin
      shift_acc = shift_acc | pos_match[i];
      if (shift_acc) begin
        order_nxt[i*WAY_W +: WAY_W] = order[(i+1)*WAY_W +: WAY_W];
      end
    end
    order_nxt[(WAYS-1)*WAY_W +: WAY_W] = way;

    tag_row_nxt = tag_row;
    valid_nxt   = valid;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && (way == WAY_W'(w))) begin
        tag_row_nxt[w*TAG_W +: TAG_W] = tag;
        valid_nxt[w]                  = 1'b1;
      end
    end
  end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for set_assoc_cache_lru_lookup
// Drives byte addresses into the tag lookup and checks the hit flag and way
// of every result against a hand-typed value or a behavioral copy of the
// tag store, valid bits and true LRU order. A short table of directed
// addresses is followed by random traffic aimed at a few hot sets and tags,
// so that hits, evictions and LRU reordering all get exercised. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench import sac_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_COUNT   = SAC_CACHE_BYTES / (SAC_BLOCK_BYTES * SAC_WAYS);
  localparam int OFS_W       = $clog2(SAC_BLOCK_BYTES);
  localparam int SET_W       = $clog2(SET_COUNT);
  localparam int TAG_W       = SAC_ADDR_PORT_W - OFS_W - SET_W;
  localparam int RANDOM_ITEMS = 1300;
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_REPORTS = 10;
  localparam int EXP_DEPTH   = 16;

  typedef struct packed {
    logic [31:0] addr;
    bit          typed;
    bit          hit;
    logic [2:0]  way;
  } dir_row_t;

  typedef struct packed {
    bit         hit;
    logic [2:0] way;
  } lookup_result_t;

  // Hand-worked rows: fill set 0 past its eight ways, evict in LRU order,
  // and touch the top set and the offset extremes.
  localparam int NUM_DIR = 20;
  localparam dir_row_t DIR_ROWS [0:NUM_DIR-1] = '{
    '{32'h0000_0000, 1'b1, 1'b0, 3'd0},
    '{32'h0000_003F, 1'b1, 1'b1, 3'd0},
    '{32'hFFFF_FFFF, 1'b1, 1'b0, 3'd0},
    '{32'hFFFF_8000, 1'b1, 1'b0, 3'd1},
    '{32'h0001_0000, 1'b1, 1'b0, 3'd2},
    '{32'h0001_8000, 1'b1, 1'b0, 3'd3},
    '{32'h0002_0000, 1'b1, 1'b0, 3'd4},
    '{32'h0002_8000, 1'b1, 1'b0, 3'd5},
    '{32'h0003_0000, 1'b1, 1'b0, 3'd6},
    '{32'h0003_8000, 1'b1, 1'b0, 3'd7},
    '{32'h0004_0000, 1'b1, 1'b0, 3'd0},
    '{32'h0000_0000, 1'b1, 1'b0, 3'd1},
    '{32'hFFFF_8000, 1'b1, 1'b0, 3'd2},
    '{32'h0002_8000, 1'b1, 1'b1, 3'd5},
    '{32'h0004_8000, 1'b1, 1'b0, 3'd3},
    '{32'h0000_0040, 1'b1, 1'b0, 3'd0},
    '{32'h0000_7FC0, 1'b1, 1'b0, 3'd1},
    '{32'hFFFF_FFC0, 1'b1, 1'b1, 3'd0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 3'd0},
    '{32'h5555_5555, 1'b0, 1'b0, 3'd0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] address
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [0] hit, [3:1] way_used, [7:4] zero

  // shadow of the cache state
  logic [TAG_W-1:0] way_tag   [SET_COUNT][SAC_WAYS];
  bit               way_valid [SET_COUNT][SAC_WAYS];
  int               lru_rank  [SET_COUNT][SAC_WAYS];

  // expected results in flight, written by the sender, read by the checker
  lookup_result_t exp_ring [EXP_DEPTH];
  int  exp_wr_cnt;
  int  exp_rd_cnt;
  int  fail_count;
  int  mismatch_count;
  int  results_seen;
  int  quiet_cycles;

  set_assoc_cache_lru_lookup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic void clear_cache_model();
    for (int s = 0; s < SET_COUNT; s++) begin
      for (int w = 0; w < SAC_WAYS; w++) begin
        way_tag[s][w]   = '0;
        way_valid[s][w] = 1'b0;
        lru_rank[s][w]  = w;
      end
    end
  endfunction

  // Move a way to the most recent end of its set's order.
  function automatic void promote_way(input int s, input int way);
    int pos;
    pos = 0;
    while (pos < SAC_WAYS && lru_rank[s][pos] != way) pos++;
    if (pos >= SAC_WAYS) pos = SAC_WAYS - 1;
    for (int i = pos; i + 1 < SAC_WAYS; i++) lru_rank[s][i] = lru_rank[s][i + 1];
    lru_rank[s][SAC_WAYS - 1] = way;
  endfunction

  function automatic lookup_result_t predict_lookup(input logic [31:0] addr);
    lookup_result_t r;
    int s;
    int victim;
    logic [TAG_W-1:0] tag;
    s   = int'(addr[OFS_W +: SET_W]);
    tag = addr[OFS_W + SET_W +: TAG_W];
    for (int w = 0; w < SAC_WAYS; w++) begin
      if (way_valid[s][w] && way_tag[s][w] == tag) begin
        promote_way(s, w);
        r.hit = 1'b1;
        r.way = 3'(w);
        return r;
      end
    end
    victim = lru_rank[s][0];
    if (victim >= SAC_WAYS) victim = 0;
    promote_way(s, victim);
    way_tag[s][victim]   = tag;
    way_valid[s][victim] = 1'b1;
    r.hit = 1'b0;
    r.way = 3'(victim);
    return r;
  endfunction

  // Offer one address, wait for the handshake, queue its expected result.
  task automatic issue_access(input logic [31:0] addr, input int gap, input bit typed,
                              input lookup_result_t typed_result);
    lookup_result_t r;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    r = predict_lookup(addr);
    exp_ring[exp_wr_cnt % EXP_DEPTH] = typed ? typed_result : r;
    exp_wr_cnt++;
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (exp_rd_cnt == exp_wr_cnt) begin
        fail_count++;
        if (mismatch_count < MAX_REPORTS)
          $display("ERROR: unexpected result item hit=%0b way=%0d",
                   out_tdata[0], out_tdata[3:1]);
        mismatch_count++;
      end else begin
        want = exp_ring[exp_rd_cnt % EXP_DEPTH];
        exp_rd_cnt++;
        if (out_tdata[0] !== want.hit || out_tdata[3:1] !== want.way) begin
          fail_count++;
          if (mismatch_count < MAX_REPORTS)
            $display("ERROR: result %0d: expected hit=%0b way=%0d, got hit=%0b way=%0d",
                     results_seen, want.hit, want.way, out_tdata[0], out_tdata[3:1]);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ERROR: timeout, no item moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result receiver
  initial begin
    int gap;
    bit burst;
    burst = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) burst = ~burst;
      gap = burst ? 0 : $urandom_range(0, 11);
      // hold off once long enough for the block to back up its input
      if (results_seen == 200) gap = LONG_HOLD;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // stimulus and end of run
  initial begin
    logic [TAG_W-1:0] hot_tags [12];
    logic [SET_W-1:0] hot_sets [4];
    logic [31:0] addr;
    lookup_result_t typed_result;
    int gap;
    int drain;
    bit burst;

    fail_count     = 0;
    mismatch_count = 0;
    results_seen   = 0;
    exp_wr_cnt     = 0;
    burst          = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    clear_cache_model();

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_DIR; i++) begin
      typed_result.hit = DIR_ROWS[i].hit;
      typed_result.way = DIR_ROWS[i].way;
      issue_access(DIR_ROWS[i].addr, $urandom_range(0, 3), DIR_ROWS[i].typed, typed_result);
    end

    // a dozen tags over a few sets: enough to thrash eight ways
    foreach (hot_tags[i]) hot_tags[i] = TAG_W'($urandom);
    hot_sets[0] = '0;
    hot_sets[1] = '1;
    hot_sets[2] = SET_W'($urandom);
    hot_sets[3] = SET_W'($urandom);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        addr = {hot_tags[$urandom_range(0, 11)], hot_sets[$urandom_range(0, 3)],
                OFS_W'($urandom)};
      end else begin
        addr = $urandom;
      end
      if ($urandom_range(0, 39) == 0) burst = ~burst;
      gap = burst ? 0 : $urandom_range(0, 11);
      issue_access(addr, gap, 1'b0, typed_result);
    end
    in_tvalid <= 1'b0;

    while (exp_rd_cnt != exp_wr_cnt) @(posedge clk);
    drain = 0;
    while (drain < 20) begin
      @(posedge clk);
      drain++;
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
